>>> src/grc_pkg.sv
// Package for the grid column raycaster: default parameter values, register
// reset values, fixed-point constants and the configuration register indexes.
// Used by grid_raycast_column; it depends on nothing else.
package grc_pkg;

   localparam int DEF_MAP_WIDTH    = 32;
   localparam int DEF_MAP_HEIGHT   = 32;
   localparam int DEF_TRIG_ENTRIES = 1024;

   localparam logic [14:0] FOV_RESET   = 15'd8192;
   localparam logic [9:0]  COLS_RESET  = 10'd320;
   localparam logic [8:0]  ROWS_RESET  = 9'd180;
   localparam logic [15:0] DEPTH_RESET = 16'd32768;
   localparam logic [9:0]  STEP_RESET  = 10'd10;

   localparam logic [15:0] SIN_A        = 16'd25736;
   localparam logic [15:0] SIN_B        = 16'd10583;
   localparam logic [17:0] SIN_C        = 18'd1306;
   localparam logic [15:0] ONE_Q14      = 16'd16384;
   localparam logic [15:0] QUARTER_TURN = 16'h4000;

   localparam logic [10:0] CEIL_LIMIT  = 11'd1023;
   localparam logic [11:0] FLOOR_LIMIT = 12'd1203;

   localparam int DIV_W = 26;
   localparam int DEN_W = 17;
   localparam int CNT_W = $clog2(DIV_W + 1);

   typedef enum logic [2:0] {
      CSR_FOV   = 3'd0,
      CSR_COLS  = 3'd1,
      CSR_ROWS  = 3'd2,
      CSR_DEPTH = 3'd3,
      CSR_STEP  = 3'd4
   } csr_index_type;

endpackage

>>> src/grid_raycast_column.sv
// A cast item marches its ray up to the maximum depth; a wall or the map edge ends the
// march sooner. Each march step passes through the multiply, cell check and map read
// states, and the ray angle and the ceiling row each pass through a serial divider.
// A map row write gives no result. Results appear for one cycle on rsp_valid, in the
// same cycle that busy falls, and cannot be held off; busy is high while a cast runs.
// Top level of the column raycaster; depends on grc_pkg and grc_ram.
module grid_raycast_column import grc_pkg::*; #(
   parameter int MAP_WIDTH    = DEF_MAP_WIDTH,
   parameter int MAP_HEIGHT   = DEF_MAP_HEIGHT,
   parameter int TRIG_ENTRIES = DEF_TRIG_ENTRIES
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_op,
   input  logic [4:0]         req_row_index,
   input  logic [31:0]        req_row_walls,
   input  logic [14:0]        req_pos_x,
   input  logic [14:0]        req_pos_y,
   input  logic [15:0]        req_heading,
   input  logic [9:0]         req_column,
   output logic               rsp_valid,
   output logic [9:0]         rsp_out_column,
   output logic [15:0]        rsp_distance,
   output logic               rsp_wall_hit,
   output logic [9:0]         rsp_tex_u,
   output logic signed [10:0] rsp_ceiling_row,
   output logic [10:0]        rsp_floor_row,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wdata
);

   localparam int XW = $clog2(MAP_WIDTH);
   localparam int YW = $clog2(MAP_HEIGHT);
   localparam int TRIG_SHIFT = 16 - $clog2(TRIG_ENTRIES);

   typedef enum logic [12:0] {
      ST_IDLE      = 13'b0000000000001,
      ST_ANG_MUL   = 13'b0000000000010,
      ST_ANG_DIV   = 13'b0000000000100,
      ST_SIN_Z     = 13'b0000000001000,
      ST_SIN_Z2    = 13'b0000000010000,
      ST_SIN_T1    = 13'b0000000100000,
      ST_SIN_T2    = 13'b0000001000000,
      ST_SIN_S     = 13'b0000010000000,
      ST_MARCH_MUL = 13'b0000100000000,
      ST_MARCH_CHK = 13'b0001000000000,
      ST_MARCH_RD  = 13'b0010000000000,
      ST_ROW_MUL   = 13'b0100000000000,
      ST_ROW_DIV   = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;

   logic [14:0] fov_ff;
   logic [9:0]  cols_ff;
   logic [8:0]  rows_ff;
   logic [15:0] depth_ff;
   logic [9:0]  step_ff;
   logic [MAP_HEIGHT-1:0] row_valid_ff, row_valid_in;

   logic [9:0]  col_ff, col_in;
   logic [14:0] px_ff, px_in, py_ff, py_in;
   logic [15:0] head_ff, head_in;
   logic [15:0] phase_ff, phase_in;
   logic        sel_ff, sel_in;
   logic [14:0] z_ff, z_in, z2_ff, z2_in;
   logic signed [15:0] sn_ff, sn_in, cs_ff, cs_in;
   logic signed [35:0] prod_ff, prod2_ff;
   logic signed [17:0] mul_a, mul_b;
   logic [16:0] dist_ff, dist_in;
   logic [DEN_W-1:0] div_rem_ff, div_rem_in, div_den_ff, div_den_in;
   logic [DIV_W-1:0] div_quo_ff, div_quo_in;
   logic [CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic        neg_ff, neg_in;
   logic [XW-1:0] cell_x_ff, cell_x_in;
   logic [YW-1:0] cell_y_ff, cell_y_in;
   logic [9:0]  frac_x_ff, frac_x_in, frac_y_ff, frac_y_in;
   logic        hit_ff, hit_in;
   logic [9:0]  tex_u_ff, tex_u_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [9:0]         rsp_col_ff, rsp_col_in;
   logic [15:0]        rsp_dist_ff, rsp_dist_in;
   logic               rsp_hit_ff, rsp_hit_in;
   logic [9:0]         rsp_tex_ff, rsp_tex_in;
   logic signed [10:0] rsp_ceil_ff, rsp_ceil_in;
   logic [10:0]        rsp_floor_ff, rsp_floor_in;

   logic              accept, row_wr_en, ram_rd_en;
   logic [YW-1:0]     row_wr_addr;
   logic [MAP_WIDTH-1:0] ram_rd_data;
   logic [9:0]        cols_eff, step_eff;
   logic [16:0]       advance;
   logic [DEN_W:0]    rem_shift;
   logic              div_ge;
   logic [DEN_W-1:0]  rem_step;
   logic [15:0]       ang;
   logic [15:0]       sin_phase;
   logic [14:0]       sin_z;
   logic signed [35:0] p14, q14;
   logic [15:0]       sin_mag;
   logic signed [18:0] tx, ty;
   logic              out_of_map;
   logic signed [11:0] dx, dy;
   logic              x_face, wall;
   logic signed [26:0] num;
   logic [DIV_W-1:0]  num_mag;
   logic signed [11:0] ceil_val, floor_val;

   grc_ram #(
      .WIDTH(MAP_WIDTH),
      .DEPTH(MAP_HEIGHT)
   ) u_map (
      .clock  (clock),
      .wr_en  (row_wr_en),
      .wr_addr(row_wr_addr),
      .wr_data(MAP_WIDTH'(req_row_walls)),
      .rd_en  (ram_rd_en),
      .rd_addr(cell_y_in),
      .rd_data(ram_rd_data)
   );

   assign busy        = (state_ff != ST_IDLE);
   assign accept      = start && !busy;
   assign row_wr_en   = accept && !req_op && (int'(req_row_index) < MAP_HEIGHT);
   assign row_wr_addr = YW'(req_row_index);

   assign cols_eff  = (cols_ff == 10'd0) ? 10'd1 : cols_ff;
   assign step_eff  = (step_ff == 10'd0) ? 10'd1 : step_ff;
   assign advance   = dist_ff + {7'd0, step_eff};

   assign rem_shift = {div_rem_ff, div_quo_ff[DIV_W-1]};
   assign div_ge    = (rem_shift >= {1'b0, div_den_ff});
   assign rem_step  = div_ge ? DEN_W'(rem_shift - {1'b0, div_den_ff}) : DEN_W'(rem_shift);

   assign ang       = head_ff - {2'd0, fov_ff[14:1]} + div_quo_ff[15:0];

   assign sin_phase = phase_ff + (sel_ff ? QUARTER_TURN : 16'd0);
   assign sin_z     = sin_phase[14] ? 15'(ONE_Q14 - {2'd0, sin_phase[13:0]})
                                    : {1'b0, sin_phase[13:0]};
   assign p14       = prod_ff >>> 14;
   assign q14       = prod2_ff >>> 14;
   assign sin_mag   = (p14[15:0] > ONE_Q14) ? ONE_Q14 : p14[15:0];

   assign tx = $signed({4'd0, px_ff}) + $signed(p14[18:0]);
   assign ty = $signed({4'd0, py_ff}) + $signed(q14[18:0]);
   assign out_of_map = tx[18] || ty[18] || (int'(tx[17:10]) >= MAP_WIDTH)
                       || (int'(ty[17:10]) >= MAP_HEIGHT);

   assign dx = $signed({2'd0, frac_x_ff}) - 12'sd512;
   assign dy = $signed({2'd0, frac_y_ff}) - 12'sd512;
   always_comb begin
      if ((dx == 12'sd0 && dy == 12'sd0) || (-dx <= dy && dy < dx)) begin
         x_face = 1'b0;
      end else if (dy > 12'sd0 && -dy < dx && dx <= dy) begin
         x_face = 1'b1;
      end else if (dy < 12'sd0 && dy <= dx && dx < -dy) begin
         x_face = 1'b1;
      end else begin
         x_face = 1'b0;
      end
   end
   assign wall = row_valid_ff[cell_y_ff] && ram_rd_data[cell_x_ff];

   assign num     = $signed({1'b0, prod_ff[25:0]}) - $signed({7'd0, rows_ff, 11'd0});
   assign num_mag = num[26] ? DIV_W'(-num) : num[25:0];

   always_comb begin
      if (dist_ff == 17'd0) begin
         ceil_val = -$signed({1'b0, CEIL_LIMIT});
      end else if (neg_ff) begin
         if (div_quo_ff > DIV_W'(CEIL_LIMIT)) begin
            ceil_val = -$signed({1'b0, CEIL_LIMIT});
         end else begin
            ceil_val = -$signed({1'b0, div_quo_ff[10:0]});
         end
      end else begin
         ceil_val = $signed({1'b0, div_quo_ff[10:0]});
      end
      floor_val = $signed({3'd0, rows_ff}) - ceil_val;
      if (floor_val > $signed(FLOOR_LIMIT)) begin
         floor_val = $signed(FLOOR_LIMIT);
      end
   end

   always_comb begin
      state_in     = state_ff;
      row_valid_in = row_valid_ff;
      col_in       = col_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      head_in      = head_ff;
      phase_in     = phase_ff;
      sel_in       = sel_ff;
      z_in         = z_ff;
      z2_in        = z2_ff;
      sn_in        = sn_ff;
      cs_in        = cs_ff;
      dist_in      = dist_ff;
      div_rem_in   = div_rem_ff;
      div_quo_in   = div_quo_ff;
      div_den_in   = div_den_ff;
      div_cnt_in   = div_cnt_ff;
      neg_in       = neg_ff;
      cell_x_in    = cell_x_ff;
      cell_y_in    = cell_y_ff;
      frac_x_in    = frac_x_ff;
      frac_y_in    = frac_y_ff;
      hit_in       = hit_ff;
      tex_u_in     = tex_u_ff;
      rsp_valid_in = 1'b0;
      rsp_col_in   = rsp_col_ff;
      rsp_dist_in  = rsp_dist_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_tex_in   = rsp_tex_ff;
      rsp_ceil_in  = rsp_ceil_ff;
      rsp_floor_in = rsp_floor_ff;
      ram_rd_en    = 1'b0;
      mul_a        = 18'sd0;
      mul_b        = 18'sd0;
      if (row_wr_en) begin
         row_valid_in[row_wr_addr] = 1'b1;
      end
      unique case (state_ff)
         ST_IDLE: begin
            mul_a = $signed({8'd0, req_column});
            mul_b = $signed({3'd0, fov_ff});
            if (accept && req_op) begin
               col_in   = req_column;
               px_in    = req_pos_x;
               py_in    = req_pos_y;
               head_in  = req_heading;
               dist_in  = 17'd0;
               hit_in   = 1'b0;
               tex_u_in = 10'd0;
               state_in = ST_ANG_MUL;
            end
         end
         ST_ANG_MUL: begin
            div_rem_in = '0;
            div_quo_in = prod_ff[DIV_W-1:0];
            div_den_in = DEN_W'(cols_eff);
            div_cnt_in = CNT_W'(DIV_W);
            state_in   = ST_ANG_DIV;
         end
         ST_ANG_DIV: begin
            if (div_cnt_ff != '0) begin
               div_rem_in = rem_step;
               div_quo_in = {div_quo_ff[DIV_W-2:0], div_ge};
               div_cnt_in = div_cnt_ff - 1'b1;
            end else begin
               phase_in = {ang[15:TRIG_SHIFT], TRIG_SHIFT'(0)};
               sel_in   = 1'b0;
               state_in = ST_SIN_Z;
            end
         end
         ST_SIN_Z: begin
            z_in     = sin_z;
            mul_a    = $signed({3'd0, sin_z});
            mul_b    = $signed({3'd0, sin_z});
            state_in = ST_SIN_Z2;
         end
         ST_SIN_Z2: begin
            z2_in    = p14[14:0];
            mul_a    = $signed(SIN_C);
            mul_b    = $signed({3'd0, p14[14:0]});
            state_in = ST_SIN_T1;
         end
         ST_SIN_T1: begin
            mul_a    = $signed({2'd0, SIN_B - p14[15:0]});
            mul_b    = $signed({3'd0, z2_ff});
            state_in = ST_SIN_T2;
         end
         ST_SIN_T2: begin
            mul_a    = $signed({2'd0, SIN_A - p14[15:0]});
            mul_b    = $signed({3'd0, z_ff});
            state_in = ST_SIN_S;
         end
         ST_SIN_S: begin
            if (!sel_ff) begin
               sn_in    = sin_phase[15] ? -$signed(sin_mag) : $signed(sin_mag);
               sel_in   = 1'b1;
               state_in = ST_SIN_Z;
            end else begin
               cs_in = sin_phase[15] ? -$signed(sin_mag) : $signed(sin_mag);
               if (advance >= {1'b0, depth_ff}) begin
                  dist_in  = {1'b0, depth_ff};
                  state_in = ST_ROW_MUL;
               end else begin
                  dist_in  = advance;
                  state_in = ST_MARCH_MUL;
               end
            end
         end
         ST_MARCH_MUL: begin
            mul_a    = $signed({{2{cs_ff[15]}}, cs_ff});
            mul_b    = $signed({1'b0, dist_ff});
            state_in = ST_MARCH_CHK;
         end
         ST_MARCH_CHK: begin
            cell_x_in = tx[10 +: XW];
            cell_y_in = ty[10 +: YW];
            frac_x_in = tx[9:0];
            frac_y_in = ty[9:0];
            if (out_of_map) begin
               dist_in  = {1'b0, depth_ff};
               state_in = ST_ROW_MUL;
            end else begin
               ram_rd_en = 1'b1;
               state_in  = ST_MARCH_RD;
            end
         end
         ST_MARCH_RD: begin
            if (wall) begin
               hit_in   = 1'b1;
               tex_u_in = x_face ? frac_x_ff : frac_y_ff;
               state_in = ST_ROW_MUL;
            end else if (advance >= {1'b0, depth_ff}) begin
               dist_in  = {1'b0, depth_ff};
               state_in = ST_ROW_MUL;
            end else begin
               dist_in  = advance;
               state_in = ST_MARCH_MUL;
            end
         end
         ST_ROW_MUL: begin
            mul_a    = $signed({9'd0, rows_ff});
            mul_b    = $signed({1'b0, dist_ff});
            state_in = ST_ROW_DIV;
            div_cnt_in = '0;
         end
         ST_ROW_DIV: begin
            state_in = ST_ROW_DIV;
            if (div_cnt_ff != '0) begin
               div_rem_in = rem_step;
               div_quo_in = {div_quo_ff[DIV_W-2:0], div_ge};
               div_cnt_in = div_cnt_ff - 1'b1;
               if (div_cnt_ff == CNT_W'(1)) begin
                  div_cnt_in = '1;
               end
            end else begin
               div_rem_in = '0;
               div_quo_in = num_mag;
               div_den_in = {dist_ff[15:0], 1'b0};
               neg_in     = num[26];
               div_cnt_in = (dist_ff == 17'd0) ? '1 : CNT_W'(DIV_W);
            end
            if (div_cnt_ff == '1) begin
               rsp_valid_in = 1'b1;
               rsp_col_in   = col_ff;
               rsp_dist_in  = dist_ff[15:0];
               rsp_hit_in   = hit_ff;
               rsp_tex_in   = tex_u_ff;
               rsp_ceil_in  = 11'(ceil_val);
               rsp_floor_in = 11'(floor_val);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
         fov_ff       <= FOV_RESET;
         cols_ff      <= COLS_RESET;
         rows_ff      <= ROWS_RESET;
         depth_ff     <= DEPTH_RESET;
         step_ff      <= STEP_RESET;
      end else begin
         state_ff     <= state_in;
         row_valid_ff <= row_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_FOV:   fov_ff   <= csr_wdata[14:0];
               CSR_COLS:  cols_ff  <= csr_wdata[9:0];
               CSR_ROWS:  rows_ff  <= csr_wdata[8:0];
               CSR_DEPTH: depth_ff <= csr_wdata;
               CSR_STEP:  step_ff  <= csr_wdata[9:0];
               default: begin
               end
            endcase
         end
      end
      col_ff       <= col_in;
      px_ff        <= px_in;
      py_ff        <= py_in;
      head_ff      <= head_in;
      phase_ff     <= phase_in;
      sel_ff       <= sel_in;
      z_ff         <= z_in;
      z2_ff        <= z2_in;
      sn_ff        <= sn_in;
      cs_ff        <= cs_in;
      prod_ff      <= mul_a * mul_b;
      prod2_ff     <= $signed({{2{sn_ff[15]}}, sn_ff}) * $signed({1'b0, dist_ff});
      dist_ff      <= dist_in;
      div_rem_ff   <= div_rem_in;
      div_quo_ff   <= div_quo_in;
      div_den_ff   <= div_den_in;
      div_cnt_ff   <= div_cnt_in;
      neg_ff       <= neg_in;
      cell_x_ff    <= cell_x_in;
      cell_y_ff    <= cell_y_in;
      frac_x_ff    <= frac_x_in;
      frac_y_ff    <= frac_y_in;
      hit_ff       <= hit_in;
      tex_u_ff     <= tex_u_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_dist_ff  <= rsp_dist_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_tex_ff   <= rsp_tex_in;
      rsp_ceil_ff  <= rsp_ceil_in;
      rsp_floor_ff <= rsp_floor_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_column  = rsp_col_ff;
   assign rsp_distance    = rsp_dist_ff;
   assign rsp_wall_hit    = rsp_hit_ff;
   assign rsp_tex_u       = rsp_tex_ff;
   assign rsp_ceiling_row = rsp_ceil_ff;
   assign rsp_floor_row   = rsp_floor_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe lasted more than one cycle");

   assert property (@(posedge clock) disable iff (reset)
      ram_rd_en |=> (state_ff == ST_MARCH_RD))
      else $error("map read data not consumed in the following cycle");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_wall_hit |-> (rsp_distance < depth_ff))
      else $error("wall hit reported at or beyond the maximum depth");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_wall_hit |-> (rsp_tex_u == 10'd0))
      else $error("texture coordinate set on an item without a hit");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ANG_DIV) && (div_cnt_ff != '0)
      |=> (div_cnt_ff == $past(div_cnt_ff) - 1'b1))
      else $error("angle divider count skipped a step");
`endif

endmodule

>>> src/grc_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Standalone; used for the wall bitmap of grid_raycast_column.
module grc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

>>> bench/tb_grid_raycast_column.sv
// Self-checking testbench for grid_raycast_column: a table of directed items, casts at
// extreme settings, then random map writes and casts, each cast predicted and compared field by field.
// Depends on grc_pkg and the grid_raycast_column RTL.
module tb_grid_raycast_column import grc_pkg::*; ;

   localparam int STALL_LIMIT = 300000;

   typedef struct {
      bit [9:0]  column;
      bit [15:0] distance;
      bit        wall_hit;
      bit [9:0]  tex_u;
      bit [10:0] ceiling_row;
      bit [10:0] floor_row;
   } cast_result_type;

   typedef struct {
      bit              op;
      bit [4:0]        row_index;
      bit [31:0]       row_walls;
      bit [14:0]       pos_x;
      bit [14:0]       pos_y;
      bit [15:0]       heading;
      bit [9:0]        column;
      bit              fixed;
      cast_result_type want;
   } item_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic               req_op = 1'b0;
   logic [4:0]         req_row_index = '0;
   logic [31:0]        req_row_walls = '0;
   logic [14:0]        req_pos_x = '0;
   logic [14:0]        req_pos_y = '0;
   logic [15:0]        req_heading = '0;
   logic [9:0]         req_column = '0;
   logic               rsp_valid;
   logic [9:0]         rsp_out_column;
   logic [15:0]        rsp_distance;
   logic               rsp_wall_hit;
   logic [9:0]         rsp_tex_u;
   logic signed [10:0] rsp_ceiling_row;
   logic [10:0]        rsp_floor_row;
   logic               csr_we = 1'b0;
   logic [2:0]         csr_index = '0;
   logic [15:0]        csr_wdata = '0;

   grid_raycast_column dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   bit [31:0]       wall_rows [32];
   longint          fov_q, cols_q, rows_q, depth_q, step_q;
   cast_result_type pending_casts [$];
   item_type        directed [$];
   int              mismatches = 0;
   int              quiet_cycles = 0;

   task automatic note_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      mismatches++;
   endtask

   function automatic longint sine_q14(input longint phase);
      longint q, z, z2, t, s;
      q = (phase >> 14) & 3;
      z = phase & 16'h3FFF;
      if (q & 1) z = 16384 - z;
      z2 = (z * z) >> 14;
      t = 10583 - ((1306 * z2) >> 14);
      t = 25736 - ((t * z2) >> 14);
      s = (t * z) >> 14;
      if (s > 16384) s = 16384;
      return (q >= 2) ? -s : s;
   endfunction

   function automatic cast_result_type cast_ray(input item_type it);
      cast_result_type r;
      longint cols, step, ang, idx, phase, sn, cs, ray_len, tx, ty, cx, cy, dx, dy;
      longint u, num, den, ceil_v, floor_v;
      bit hit, ended, xface;
      cols = (cols_q != 0) ? cols_q : 1;
      step = (step_q != 0) ? step_q : 1;
      ang = (longint'(it.heading) - (fov_q >> 1) + (longint'(it.column) * fov_q) / cols)
            & 16'hFFFF;
      idx = (ang * DEF_TRIG_ENTRIES) >> 16;
      phase = (idx * 65536 / DEF_TRIG_ENTRIES) & 16'hFFFF;
      sn = sine_q14(phase);
      cs = sine_q14((phase + 16384) & 16'hFFFF);
      ray_len = 0; hit = 0; ended = 0; u = 0;
      while (!ended && ray_len < depth_q) begin
         ray_len += step;
         tx = longint'(it.pos_x) + ((cs * ray_len) >>> 14);
         ty = longint'(it.pos_y) + ((sn * ray_len) >>> 14);
         if (tx < 0 || ty < 0) begin
            ended = 1;
            ray_len = depth_q;
         end else begin
            cx = tx >> 10;
            cy = ty >> 10;
            if (cx >= DEF_MAP_WIDTH || cy >= DEF_MAP_HEIGHT) begin
               ended = 1;
               ray_len = depth_q;
            end else if (cx < 32 && wall_rows[cy][cx]) begin
               dx = tx - (cx * 1024 + 512);
               dy = ty - (cy * 1024 + 512);
               ended = 1;
               if ((dx == 0 && dy == 0) || (-dx <= dy && dy < dx)) xface = 0;
               else if (dy > 0 && -dy < dx && dx <= dy) xface = 1;
               else if (dy < 0 && dy <= dx && dx < -dy) xface = 1;
               else xface = 0;
               u = xface ? tx - cx * 1024 : ty - cy * 1024;
               if (ray_len < depth_q) hit = 1;
            end
         end
      end
      if (ray_len >= depth_q) begin
         ray_len = depth_q;
         hit = 0;
      end
      if (!hit) u = 0;
      if (ray_len == 0) begin
         ceil_v = -1023;
      end else begin
         num = rows_q * ray_len - 2048 * rows_q;
         den = 2 * ray_len;
         ceil_v = num / den;
         if (ceil_v < -1023) ceil_v = -1023;
      end
      floor_v = rows_q - ceil_v;
      if (floor_v > 1203) floor_v = 1203;
      r.column = it.column;
      r.distance = ray_len[15:0];
      r.wall_hit = hit;
      r.tex_u = u[9:0];
      r.ceiling_row = ceil_v[10:0];
      r.floor_row = floor_v[10:0];
      return r;
   endfunction

   task automatic write_reg(input csr_index_type idx, input longint value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[15:0];
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_FOV:   fov_q = value;
         CSR_COLS:  cols_q = value;
         CSR_ROWS:  rows_q = value;
         CSR_DEPTH: depth_q = value;
         CSR_STEP:  step_q = value;
         default: ;
      endcase
   endtask

   task automatic send_item(input item_type it);
      req_op <= it.op;
      req_row_index <= it.row_index;
      req_row_walls <= it.row_walls;
      req_pos_x <= it.pos_x;
      req_pos_y <= it.pos_y;
      req_heading <= it.heading;
      req_column <= it.column;
      start <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      if (it.op) begin
         if (it.fixed) pending_casts = {pending_casts, it.want};
         else pending_casts = {pending_casts, cast_ray(it)};
      end else begin
         wall_rows[it.row_index] = it.row_walls;
      end
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      do @(posedge clock); while (pending_casts.size() != 0 || busy !== 1'b0);
      repeat (5) @(posedge clock);
   endtask

   function automatic void add_directed(input item_type it);
      directed = {directed, it};
   endfunction

   function automatic item_type make_item(input bit op, input bit [4:0] ri, input bit [31:0] rw,
                                          input bit [14:0] px, input bit [14:0] py,
                                          input bit [15:0] hd, input bit [9:0] col);
      item_type it;
      it.op = op; it.row_index = ri; it.row_walls = rw;
      it.pos_x = px; it.pos_y = py; it.heading = hd; it.column = col;
      it.fixed = 0;
      it.want = '{default: 0};
      return it;
   endfunction

   function automatic item_type random_item(input bit cast);
      item_type it;
      it = make_item(cast, 5'($urandom_range(0, 31)), $urandom, 15'($urandom),
                     15'($urandom), 16'($urandom), 10'($urandom));
      if ($urandom_range(0, 3) == 0) it.row_walls = '1;
      else if ($urandom_range(0, 2) != 0) it.row_walls = $urandom & $urandom & $urandom;
      return it;
   endfunction

   always @(posedge clock) begin
      if (rsp_valid === 1'b1) begin
         if (pending_casts.size() == 0) begin
            note_mismatch("unexpected result, column", rsp_out_column, -1);
         end else begin
            cast_result_type w;
            w = pending_casts.pop_front();
            if (rsp_out_column !== w.column) note_mismatch("column", rsp_out_column, w.column);
            if (rsp_distance !== w.distance) note_mismatch("distance", rsp_distance, w.distance);
            if (rsp_wall_hit !== w.wall_hit) note_mismatch("wall_hit", rsp_wall_hit, w.wall_hit);
            if (rsp_tex_u !== w.tex_u) note_mismatch("tex_u", rsp_tex_u, w.tex_u);
            if (rsp_ceiling_row !== w.ceiling_row)
               note_mismatch("ceiling_row", rsp_ceiling_row, $signed(w.ceiling_row));
            if (rsp_floor_row !== w.floor_row)
               note_mismatch("floor_row", rsp_floor_row, w.floor_row);
         end
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || csr_we || reset) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("grid_raycast_column verification failed");
         $finish;
      end
   end

   initial begin
      item_type it;
      int total, gap, n;
      longint d;
      fov_q = FOV_RESET; cols_q = COLS_RESET; rows_q = ROWS_RESET;
      depth_q = DEPTH_RESET; step_q = STEP_RESET;
      foreach (wall_rows[i]) wall_rows[i] = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // After reset the map is open, so rays leave the map at maximum depth.
      it = make_item(1, 0, 0, 15'd16384, 15'd16384, 16'd0, 10'd160);
      it.fixed = 1; it.want = '{10'd160, 16'd32768, 1'b0, 10'd0, 11'd84, 11'd96};
      add_directed(it);
      it = make_item(1, 0, 0, 15'd0, 15'd0, 16'd32768, 10'd160);
      it.fixed = 1; it.want = '{10'd160, 16'd32768, 1'b0, 10'd0, 11'd84, 11'd96};
      add_directed(it);
      add_directed(make_item(0, 5'd0, 32'hFFFF_FFFF, 0, 0, 0, 0));
      add_directed(make_item(0, 5'd31, 32'hFFFF_FFFF, 0, 0, 0, 0));
      add_directed(make_item(0, 5'd16, 32'h8000_0001, 0, 0, 0, 0));
      add_directed(make_item(0, 5'd10, 32'h0001_0000, 0, 0, 0, 0));
      add_directed(make_item(1, 0, 0, 15'd16384, 15'd16896, 16'd0, 10'd160));
      add_directed(make_item(1, 0, 0, 15'd16384, 15'd16896, 16'd32768, 10'd160));
      add_directed(make_item(1, 0, 0, 15'd16896, 15'd16384, 16'd16384, 10'd0));
      add_directed(make_item(1, 0, 0, 15'd16896, 15'd16384, 16'd49152, 10'd319));
      add_directed(make_item(1, 0, 0, 15'd16896, 15'd20000, 16'd49152, 10'd160));
      add_directed(make_item(1, 0, 0, 15'd32767, 15'd32767, 16'd65535, 10'd1023));
      add_directed(make_item(1, 0, 0, 15'd5000, 15'd9000, 16'd8000, 10'd700));
      add_directed(make_item(1, 0, 0, 15'd1500, 15'd1500, 16'd40000, 10'd0));
      foreach (directed[i]) send_item(directed[i]);
      wait_idle();

      // Extreme settings, low and high, then random settings per phase.
      write_reg(CSR_FOV, 1); write_reg(CSR_COLS, 1); write_reg(CSR_ROWS, 1);
      write_reg(CSR_DEPTH, 1024); write_reg(CSR_STEP, 1);
      send_item(make_item(1, 0, 0, 15'd16896, 15'd16896, 16'd0, 10'd0));
      send_item(make_item(1, 0, 0, 15'd16896, 15'd16896, 16'd16384, 10'd1023));
      wait_idle();
      write_reg(CSR_FOV, 32767); write_reg(CSR_COLS, 1023); write_reg(CSR_ROWS, 511);
      write_reg(CSR_DEPTH, 65535); write_reg(CSR_STEP, 1023);
      send_item(make_item(1, 0, 0, 15'd16896, 15'd16896, 16'd0, 10'd0));
      send_item(make_item(1, 0, 0, 15'd100, 15'd30000, 16'd60000, 10'd1023));
      wait_idle();

      total = 0;
      while (total < 162) begin
         d = $urandom_range(1024, 65535);
         if ($urandom_range(0, 4) == 0) d = ($urandom_range(0, 1) != 0) ? 65535 : 1024;
         write_reg(CSR_DEPTH, d);
         write_reg(CSR_STEP, $urandom_range(d / 300 + 1, 1023));
         write_reg(CSR_FOV, $urandom_range(1, 32767));
         write_reg(CSR_COLS, $urandom_range(1, 1023));
         write_reg(CSR_ROWS, $urandom_range(1, 511));
         n = $urandom_range(10, 30);
         for (int k = 0; k < n && total < 162; k++) begin
            it = random_item($urandom_range(0, 9) >= 3);
            send_item(it);
            total++;
            if (total < 130 && $urandom_range(0, 2) == 0) begin
               gap = $urandom_range(1, 10);
               start <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         wait_idle();
      end

      repeat (100) @(posedge clock);
      if (mismatches == 0 && pending_casts.size() == 0) begin
         $display("grid_raycast_column verification clean");
      end else begin
         $display("grid_raycast_column verification failed");
      end
      $finish;
   end
endmodule
